FILE: rtl/mtme_pkg.sv
// ----------------------------------------------------------------------------
// mtme_pkg
// Shared types, byte codes and frame table for the MIDI transport encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mtme_pkg;

  // Request modes
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  // MIDI status bytes
  localparam logic [7:0] MIDI_START  = 8'hFA;
  localparam logic [7:0] MIDI_STOP   = 8'hFC;
  localparam logic [7:0] MIDI_CLOCK  = 8'hF8;
  localparam logic [7:0] SYSEX_BEGIN = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;

  // Length field of a start frame: 8 * 96 = 768, split into a high byte and a 7-bit low part
  localparam int unsigned START_LENGTH = 8 * 96;
  localparam logic [7:0]  START_LEN_HI = 8'((START_LENGTH >> 7) & 'hFF);
  localparam logic [6:0]  START_LEN_LO = 7'(START_LENGTH & 'h7F);

  // Byte positions within one request's output sequence
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_XPORT     = 5'd0;
  localparam step_t STEP_SYX_BEGIN = 5'd1;
  localparam step_t STEP_HEAD_0    = 5'd2;   // first of ten fixed header bytes
  localparam step_t STEP_HEAD_9    = 5'd11;
  localparam step_t STEP_LEN_HI    = 5'd12;
  localparam step_t STEP_LEN_LO    = 5'd13;
  localparam step_t STEP_TEMPO_HI  = 5'd14;
  localparam step_t STEP_TEMPO_LO  = 5'd15;
  localparam step_t STEP_PAD_0     = 5'd16;
  localparam step_t STEP_PAD_3     = 5'd19;
  localparam step_t STEP_CHECKSUM  = 5'd20;
  localparam step_t STEP_SYX_END   = 5'd21;
  localparam step_t STEP_CLOCK     = 5'd22;

  // Command queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Classified request handed from front to back
  typedef struct packed {
    logic       has_xport;
    logic       is_start;
    logic       has_frame;
    logic       has_clock;
    logic [7:0] tempo_hi;
    logic [6:0] tempo_lo;
    logic [6:0] checksum;
  } desc_t;

  // Fixed frame header after F0
  function automatic logic [7:0] frame_head(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h41;
      4'd1:    b = 8'h10;
      4'd4:    b = 8'h5C;
      4'd5:    b = 8'h12;
      4'd7:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mtme_front.sv
// ----------------------------------------------------------------------------
// mtme_front
// Classifies a transport request and precomputes tempo halves and checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module mtme_front (
  input  wire logic [1:0]     mode,
  input  wire logic [15:0]    tempo_tenths,
  input  wire logic           tempo_valid,
  input  wire logic           send_clock,
  output mtme_pkg::desc_t     desc,
  output logic                has_bytes
);
  import mtme_pkg::*;

  logic       xport;
  logic       start;
  logic [7:0] len_hi;
  logic [7:0] sum;

  always_comb begin
    xport  = (mode == MODE_START) || (mode == MODE_STOP);
    start  = (mode == MODE_START);
    len_hi = start ? START_LEN_HI : 8'h00;

    desc.has_xport = xport;
    desc.is_start  = start;
    desc.has_frame = xport && tempo_valid;
    desc.has_clock = send_clock;
    desc.tempo_hi  = tempo_tenths[14:7];
    desc.tempo_lo  = tempo_tenths[6:0];

    // Only the low 7 bits of the running sum reach the checksum
    sum = 8'h01 + len_hi + {1'b0, (start ? START_LEN_LO : 7'h00)}
        + tempo_tenths[14:7] + {1'b0, tempo_tenths[6:0]};
    desc.checksum = 7'(8'h80 - sum);

    has_bytes = xport || send_clock;
  end

endmodule

`default_nettype wire

FILE: rtl/mtme_queue.sv
// ----------------------------------------------------------------------------
// mtme_queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mtme_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire mtme_pkg::desc_t  push_desc,
  input  wire logic             pop,
  output mtme_pkg::desc_t       head_desc,
  output logic                  not_empty,
  output logic                  full
);
  import mtme_pkg::*;

  desc_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r,  count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_desc = mem_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mtme_back.sv
// ----------------------------------------------------------------------------
// mtme_back
// Byte sequencer: walks one request's byte positions into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtme_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mtme_pkg::desc_t  head_desc,
  input  wire logic             head_valid,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_midi_byte,
  output logic                  out_last_byte
);
  import mtme_pkg::*;

  logic       busy_r,  busy_nxt;
  step_t      step_r,  step_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r,  byte_nxt;
  logic       last_r,  last_nxt;

  step_t      cur_step;
  step_t      head_idx;
  logic       emit;
  logic       is_last;
  logic [7:0] cur_byte;

  assign out_valid     = valid_r;
  assign out_midi_byte = byte_r;
  assign out_last_byte = last_r;

  always_comb begin
    cur_step = busy_r ? step_r : (head_desc.has_xport ? STEP_XPORT : STEP_CLOCK);
    emit     = head_valid && (!valid_r || out_ready);
    head_idx = cur_step - STEP_HEAD_0;

    // last byte of the request?
    is_last = (cur_step == STEP_CLOCK)
           || ((cur_step == STEP_SYX_END) && !head_desc.has_clock)
           || ((cur_step == STEP_XPORT) && !head_desc.has_frame && !head_desc.has_clock);

    // position after this one
    if ((cur_step == STEP_XPORT) && !head_desc.has_frame) begin
      step_nxt = STEP_CLOCK;
    end else if (cur_step == STEP_SYX_END) begin
      step_nxt = STEP_CLOCK;
    end else begin
      step_nxt = cur_step + 1'b1;
    end

    case (cur_step)
      STEP_XPORT:     cur_byte = head_desc.is_start ? MIDI_START : MIDI_STOP;
      STEP_SYX_BEGIN: cur_byte = SYSEX_BEGIN;
      STEP_LEN_HI:    cur_byte = head_desc.is_start ? START_LEN_HI : 8'h00;
      STEP_LEN_LO:    cur_byte = {1'b0, (head_desc.is_start ? START_LEN_LO : 7'h00)};
      STEP_TEMPO_HI:  cur_byte = head_desc.tempo_hi;
      STEP_TEMPO_LO:  cur_byte = {1'b0, head_desc.tempo_lo};
      STEP_CHECKSUM:  cur_byte = {1'b0, head_desc.checksum};
      STEP_SYX_END:   cur_byte = SYSEX_END;
      STEP_CLOCK:     cur_byte = MIDI_CLOCK;
      default: begin
        if ((cur_step >= STEP_HEAD_0) && (cur_step <= STEP_HEAD_9)) begin
          cur_byte = frame_head(head_idx[3:0]);
        end else begin
          cur_byte = 8'h00;   // zero padding
        end
      end
    endcase

    pop       = emit && is_last;
    busy_nxt  = emit ? !is_last : busy_r;
    valid_nxt = emit ? 1'b1 : (valid_r && !out_ready);
    byte_nxt  = emit ? cur_byte : byte_r;
    last_nxt  = emit ? is_last : last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
    if (emit) begin
      step_r <= step_nxt;
    end
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/midi_transport_message_encoder.sv
// ----------------------------------------------------------------------------
// midi_transport_message_encoder
// Turns transport requests into a MIDI byte stream with optional tempo SysEx.
// ----------------------------------------------------------------------------
// A request (mode, tempo in tenths of BPM, tempo_valid, send_clock) produces
// 0 to 23 bytes on the out_ channel, one byte per cycle while out_ready is
// high: FA (start) or FC (stop), then, with a valid tempo, the 21-byte
// system-exclusive tempo frame ending in checksum and F7, then F8 when a
// timing clock is requested. out_last_byte marks the final byte of each
// request. A request with mode none and no clock produces nothing. A request
// holds the byte sequencer for its 1, 2, 22 or 23 bytes; the sequencer moves
// straight from one request's last byte to the next request's first byte, so
// the stream runs gap-free while more requests are queued. Requests are
// classified on entry and parked in a two-deep command queue, so in_ready
// stays high while the queue has room, even while bytes are still draining.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_transport_message_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_tempo_tenths,
  input  wire logic        in_tempo_valid,
  input  wire logic        in_send_clock,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_midi_byte,
  output logic             out_last_byte
);
  import mtme_pkg::*;

  desc_t front_desc;
  desc_t head_desc;
  logic  front_has_bytes;
  logic  q_push;
  logic  q_pop;
  logic  q_not_empty;
  logic  q_full;

  // Front: classification, tempo split, checksum
  mtme_front u_front (
    .mode         (in_mode),
    .tempo_tenths (in_tempo_tenths),
    .tempo_valid  (in_tempo_valid),
    .send_clock   (in_send_clock),
    .desc         (front_desc),
    .has_bytes    (front_has_bytes)
  );

  // Accept whenever the queue has room; empty requests are dropped here
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && front_has_bytes;

  mtme_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (front_desc),
    .pop       (q_pop),
    .head_desc (head_desc),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Back: byte sequencer and output register
  mtme_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_desc     (head_desc),
    .head_valid    (q_not_empty),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_midi_byte (out_midi_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

`default_nettype wire

FILE: verif/tb_midi_transport_message_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_transport_message_encoder
// Self-checking bench for the MIDI transport encoder byte stream.
// ----------------------------------------------------------------------------
// A short table of hand-picked requests runs first. These cover empty
// requests, bare status bytes, the unused mode, tempo extremes and tempo
// bit 15. A few hundred random requests follow, biased toward start/stop
// with a tempo frame. Every output byte is checked in order against
// typed bytes or a local encoder model. Both sides throttle at random,
// with one stretch that runs at full rate.
// ----------------------------------------------------------------------------

module tb_midi_transport_message_encoder;
  import mtme_pkg::*;

  localparam logic [1:0]  MODE_UNUSED  = 2'd3;   // decodes like "none"
  localparam int          RANDOM_REQS  = 300;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 40;
  // Fixed bytes between F0 and the length field
  localparam logic [79:0] SYSEX_HEADER = 80'h41_10_00_00_5C_12_00_01_00_00;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } midi_out_t;

  // One directed request. n_typed > 0 means the expected bytes are written
  // out here (b0, b1); otherwise the encoder model supplies them. Because a
  // row with n_typed of 0 is ambiguous, typed_empty marks a request that must
  // produce no bytes at all.
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] tempo;
    logic        tempo_ok;
    logic        clock;
    logic        typed_empty;
    logic [1:0]  n_typed;
    logic [7:0]  b0;
    logic [7:0]  b1;
  } directed_req_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [15:0] in_tempo_tenths;
  logic        in_tempo_valid;
  logic        in_send_clock;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_midi_byte;
  logic        out_last_byte;

  midi_out_t   expected_bytes[$];
  int          err_count;
  int          cycle_count;
  int          req_count;
  int          frame_count;
  int          bytes_checked;
  bit          full_rate;       // no idling on either side while set

  directed_req_t directed_reqs[19];

  midi_transport_message_encoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_tempo_tenths (in_tempo_tenths),
    .in_tempo_valid  (in_tempo_valid),
    .in_send_clock   (in_send_clock),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_midi_byte   (out_midi_byte),
    .out_last_byte   (out_last_byte)
  );

  // 12 ns period, first rising edge at 6 ns
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  // Encoder model: appends the bytes one request should produce.
  // Frame body runs from the header through the four padding bytes;
  // the checksum covers body bytes 6..17, summed modulo 2^16.
  task automatic predict_midi_bytes(input logic [1:0] mode, input logic [15:0] tempo,
                                    input logic tempo_ok, input logic clock);
    logic [7:0]  seq[$];
    logic [7:0]  body[18];
    logic [15:0] len;
    logic [15:0] sum;
    logic [7:0]  cs_byte;
    midi_out_t   item;
    len = 16'h0;
    sum = 16'h0;
    if (mode == MODE_START || mode == MODE_STOP) begin
      seq.insert(seq.size(), (mode == MODE_START) ? MIDI_START : MIDI_STOP);
      if (tempo_ok) begin
        len = (mode == MODE_START) ? 16'(START_LENGTH) : 16'h0;
        for (int i = 0; i < 10; i++)
          body[i] = SYSEX_HEADER[79 - 8*i -: 8];
        body[10] = len[14:7];
        body[11] = {1'b0, len[6:0]};
        body[12] = tempo[14:7];        // bit 15 is dropped
        body[13] = {1'b0, tempo[6:0]};
        for (int i = 14; i < 18; i++)
          body[i] = 8'h00;
        for (int i = 6; i < 18; i++)
          sum = sum + 16'(body[i]);
        seq.insert(seq.size(), SYSEX_BEGIN);
        for (int i = 0; i < 18; i++)
          seq.insert(seq.size(), body[i]);
        cs_byte = {1'b0, 7'(16'h80 - sum)};
        seq.insert(seq.size(), cs_byte);
        seq.insert(seq.size(), SYSEX_END);
        frame_count++;
      end
    end
    if (clock)
      seq.insert(seq.size(), MIDI_CLOCK);
    foreach (seq[i]) begin
      item.data = seq[i];
      item.last = (i == seq.size() - 1);
      expected_bytes.insert(expected_bytes.size(), item);
    end
  endtask

  // Drive one request and hold it until accepted. On return we sit at the
  // accepting edge with in_valid still high; the next call (or the caller)
  // decides whether it stays high or drops.
  task automatic send_request(input logic [1:0] mode, input logic [15:0] tempo,
                              input logic tempo_ok, input logic clock);
    int gap;
    if (!full_rate && $urandom_range(99) < 17) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_tempo_tenths <= tempo;
    in_tempo_valid  <= tempo_ok;
    in_send_clock   <= clock;
    do
      @(posedge clk);
    while (!in_ready);
    req_count++;
  endtask

  // Sender stalls until the encoder has drained everything in flight
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do
      @(posedge clk);
    while (expected_bytes.size() != 0);
  endtask

  // Output side: check each transaction, then pick next cycle's ready
  always @(posedge clk) begin
    midi_out_t want;
    if (rst_n && out_valid && out_ready) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h (last=%0b)",
                                  out_midi_byte, out_last_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (out_midi_byte !== want.data)
          report_mismatch($sformatf("midi_byte got %02h want %02h",
                                    out_midi_byte, want.data));
        if (out_last_byte !== want.last)
          report_mismatch($sformatf("last_byte got %0b want %0b on byte %02h",
                                    out_last_byte, want.last, want.data));
      end
    end
    out_ready <= full_rate ? 1'b1 : ($urandom_range(99) >= 17);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected",
               cycle_count, expected_bytes.size());
      $display("** midi_transport_message_encoder: FAILED **");
      $finish;
    end
  end

  initial begin
    directed_reqs = '{
      // mode         tempo     ok    clk   empty n     b0           b1
      '{MODE_NONE,    16'h0000, 1'b0, 1'b0, 1'b1, 2'd0, 8'h00,       8'h00},
      '{MODE_NONE,    16'h0000, 1'b0, 1'b1, 1'b0, 2'd1, MIDI_CLOCK,  8'h00},
      '{MODE_START,   16'h0000, 1'b0, 1'b0, 1'b0, 2'd1, MIDI_START,  8'h00},
      '{MODE_STOP,    16'h0000, 1'b0, 1'b0, 1'b0, 2'd1, MIDI_STOP,   8'h00},
      '{MODE_START,   16'hFFFF, 1'b0, 1'b1, 1'b0, 2'd2, MIDI_START,  MIDI_CLOCK},
      '{MODE_STOP,    16'hFFFF, 1'b0, 1'b1, 1'b0, 2'd2, MIDI_STOP,   MIDI_CLOCK},
      // unused mode behaves like none, tempo flag ignored
      '{MODE_UNUSED,  16'hFFFF, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00,       8'h00},
      '{MODE_UNUSED,  16'h0000, 1'b1, 1'b1, 1'b0, 2'd1, MIDI_CLOCK,  8'h00},
      '{MODE_NONE,    16'h04D2, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00,       8'h00},
      // full frames, checked against the model
      '{MODE_START,   16'h0000, 1'b1, 1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
      '{MODE_START,   16'hFFFF, 1'b1, 1'b1, 1'b0, 2'd0, 8'h00,       8'h00},
      '{MODE_STOP,    16'h0000, 1'b1, 1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
      '{MODE_STOP,    16'h7FFF, 1'b1, 1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
      '{MODE_STOP,    16'h8000, 1'b1, 1'b1, 1'b0, 2'd0, 8'h00,       8'h00},
      '{MODE_START,   16'h0001, 1'b1, 1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
      '{MODE_START,   16'h0080, 1'b1, 1'b1, 1'b0, 2'd0, 8'h00,       8'h00},
      '{MODE_STOP,    16'hAAAA, 1'b1, 1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
      '{MODE_STOP,    16'h5555, 1'b1, 1'b1, 1'b0, 2'd0, 8'h00,       8'h00},
      '{MODE_START,   16'd1200, 1'b1, 1'b1, 1'b0, 2'd0, 8'h00,       8'h00}
    };
  end

  initial begin
    logic [1:0]  mode;
    logic [15:0] tempo;
    logic        tempo_ok;
    logic        clock;
    int          pick;
    int          calm_from;
    midi_out_t   item;

    err_count       = 0;
    cycle_count     = 0;
    req_count       = 0;
    frame_count     = 0;
    bytes_checked   = 0;
    full_rate       = 1'b0;
    calm_from       = $urandom_range(120, 180);
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_mode         <= MODE_NONE;
    in_tempo_tenths <= 16'h0;
    in_tempo_valid  <= 1'b0;
    in_send_clock   <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (directed_reqs[r]) begin
      send_request(directed_reqs[r].mode, directed_reqs[r].tempo,
                   directed_reqs[r].tempo_ok, directed_reqs[r].clock);
      if (directed_reqs[r].typed_empty) begin
        // nothing expected
      end else if (directed_reqs[r].n_typed != 0) begin
        item.data = directed_reqs[r].b0;
        item.last = (directed_reqs[r].n_typed == 2'd1);
        expected_bytes.insert(expected_bytes.size(), item);
        if (directed_reqs[r].n_typed == 2'd2) begin
          item.data = directed_reqs[r].b1;
          item.last = 1'b1;
          expected_bytes.insert(expected_bytes.size(), item);
        end
      end else begin
        predict_midi_bytes(directed_reqs[r].mode, directed_reqs[r].tempo,
                           directed_reqs[r].tempo_ok, directed_reqs[r].clock);
      end
    end
    wait_for_drain();

    // Random requests: mostly start/stop carrying a tempo frame
    for (int n = 0; n < RANDOM_REQS; n++) begin
      full_rate = (n >= calm_from && n < calm_from + 60);
      if (n == 100)
        wait_for_drain();
      pick = $urandom_range(99);
      if (pick < 40)      mode = MODE_START;
      else if (pick < 80) mode = MODE_STOP;
      else if (pick < 90) mode = MODE_NONE;
      else                mode = MODE_UNUSED;
      pick = $urandom_range(9);
      if (pick == 0)      tempo = 16'h0000;
      else if (pick == 1) tempo = 16'hFFFF;
      else if (pick == 2) tempo = 16'($urandom_range(1, 65535)) & 16'h7FFF;
      else                tempo = 16'($urandom);
      tempo_ok = ($urandom_range(99) < 75);
      clock    = 1'($urandom_range(1));
      send_request(mode, tempo, tempo_ok, clock);
      predict_midi_bytes(mode, tempo, tempo_ok, clock);
    end
    full_rate = 1'b0;

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests, %0d with a tempo frame; %0d bytes checked.",
             req_count, frame_count, bytes_checked);
    $display("Mismatches: %0d", err_count);
    if (err_count == 0) begin
      $display("** midi_transport_message_encoder: PASSED **");
    end else begin
      $display("** midi_transport_message_encoder: FAILED **");
    end
    $finish;
  end

endmodule
